// ----- sv/ght_pkg.sv -----
// Shared types, constants and codes for the generational handle table.
package ght_pkg;

  localparam int SLOTS    = 64;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int HW_W     = $clog2(SLOTS + 1);
  localparam int GRP_SIZE = 8;
  localparam int NGRP     = SLOTS / GRP_SIZE;
  localparam int GRP_W    = $clog2(NGRP);
  localparam int LOW_W    = $clog2(GRP_SIZE);

  localparam int FUNC_W   = 2;
  localparam int HANDLE_W = 32;
  localparam int ID_W     = 6;
  localparam int GEN_W    = 32;
  localparam int STATUS_W = 3;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_ID = 3'd1;
  localparam logic [STATUS_W-1:0] ST_STALE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [HANDLE_W-1:0] handle;
    logic [ID_W-1:0]     slot_id;
    logic [GEN_W-1:0]    generation;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     out_slot;
    logic [GEN_W-1:0]    out_generation;
    logic [HANDLE_W-1:0] out_handle;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;
    logic search;
    logic pick;
    logic commit;
  } ght_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
  } ght_stat_t;

endpackage

// ----- sv/generational_handle_table_unit.sv -----
// Top level of the generational handle table: controller plus datapath.
//
// Usage:
//   Request channel (req_valid / req_ready / req): one word carries func,
//   handle, slot_id and generation. Allocate hands out the lowest free slot
//   (slot 0 is reserved) with its current generation; release frees a slot
//   and bumps its generation; lookup returns the stored handle.
//   Response channel (rsp_valid / rsp_ready / rsp): one word per request,
//   status, out_slot, out_generation and out_handle, in request order.
//   A word accepted passes the search tree level, then pick plus slot RAM
//   read, then execute, before it is presented at rsp.
//   The controller handles one request at a time and takes the next one
//   only after execute, because of the two-level free-slot search and the
//   registered read of the slot RAMs ahead of the write-back.
//   A held response does not block the next request; only the execute step
//   waits when the response register is still full and not being taken.
//   Reset (rst, synchronous): all slots free, generations read as zero,
//   high-water mark at one, response register empty.
//   No clearing pass is needed after reset.
module generational_handle_table_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ght_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ght_pkg::rsp_t rsp
);

  ght_pkg::ght_cmd_t  cmd;
  ght_pkg::ght_stat_t stat;

  ght_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ght_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

`ifndef SYNTHESIS
  // one request in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while previous one in flight");

  // commit always lands a word in the response register
  a_commit_fills_rsp: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> rsp_valid)
    else $error("commit did not produce a response word");

  // table full answers carry no slot
  a_full_no_slot: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ght_pkg::ST_FULL) |-> (rsp.out_slot == '0))
    else $error("table full response with nonzero slot");

  // a handle only comes back on a successful request
  a_handle_only_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.out_handle != '0) |-> (rsp.status == ght_pkg::ST_OK))
    else $error("handle returned with error status");
`endif

endmodule

// ----- sv/ght_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ght_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/ght_ctrl.sv -----
// Sequencing state machine for the handle table.
module ght_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  ght_pkg::ght_stat_t  stat,
  output ght_pkg::ght_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SRCH = 4'b0010,
    S_PICK = 4'b0100,
    S_EXEC = 4'b1000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_SRCH;
      end
      S_SRCH: state_next = S_PICK;
      S_PICK: state_next = S_EXEC;
      S_EXEC: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready    = (state == S_IDLE);
  assign cmd.load_req = req_valid && (state == S_IDLE);
  assign cmd.search   = (state == S_SRCH);
  assign cmd.pick     = (state == S_PICK);
  assign cmd.commit   = (state == S_EXEC) && stat.out_free;

endmodule

// ----- sv/ght_dp.sv -----
// Datapath: slot state, free-slot search, slot RAMs and the response register.
module ght_dp (
  input  logic               clk,
  input  logic               rst,
  input  ght_pkg::req_t      req,
  input  ght_pkg::ght_cmd_t  cmd,
  output ght_pkg::ght_stat_t stat,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output ght_pkg::rsp_t      rsp
);

  ght_pkg::req_t req_q;

  logic [ght_pkg::SLOTS-1:0] occupied;
  logic [ght_pkg::SLOTS-1:0] gen_valid;   // entry written since reset
  logic [ght_pkg::HW_W-1:0]  hw;

  // search tree, first level per group of eight slots
  logic [ght_pkg::SLOTS-1:0] free_vec;
  logic [ght_pkg::NGRP-1:0]  grp_any_c, grp_any;
  logic [ght_pkg::LOW_W-1:0] grp_low_c [ght_pkg::NGRP];
  logic [ght_pkg::LOW_W-1:0] grp_low   [ght_pkg::NGRP];

  logic                      pick_any;
  logic [ght_pkg::GRP_W-1:0] pick_grp;
  logic [ght_pkg::SLOT_W-1:0] alloc_slot, id_slot, rd_slot, tgt;
  logic                      alloc_full;

  logic [ght_pkg::GEN_W-1:0]    gen_rd, gen_cur;
  logic [ght_pkg::HANDLE_W-1:0] handle_rd;
  logic                         id_bad;
  logic [ght_pkg::STATUS_W-1:0] chk_st;
  ght_pkg::rsp_t                rsp_c;
  logic                         alloc_ok, rel_ok;

  always_ff @(posedge clk) begin
    if (cmd.load_req) req_q <= req;
  end

  always_comb begin
    free_vec    = ~occupied;
    free_vec[0] = 1'b0;   // reserved slot
  end

  always_comb begin
    for (int g = 0; g < ght_pkg::NGRP; g++) begin
      grp_any_c[g] = |free_vec[g*ght_pkg::GRP_SIZE +: ght_pkg::GRP_SIZE];
      grp_low_c[g] = '0;
      for (int b = ght_pkg::GRP_SIZE - 1; b >= 0; b--) begin
        if (free_vec[g*ght_pkg::GRP_SIZE + b]) grp_low_c[g] = ght_pkg::LOW_W'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      grp_any <= grp_any_c;
      grp_low <= grp_low_c;
    end
  end

  // second level: lowest group with a free slot
  always_comb begin
    pick_any = 1'b0;
    pick_grp = '0;
    for (int g = ght_pkg::NGRP - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        pick_any = 1'b1;
        pick_grp = ght_pkg::GRP_W'(g);
      end
    end
  end

  // slots at or above the mark are never occupied, so the lowest free
  // slot is either a hole below the mark or the mark itself
  assign alloc_slot = {pick_grp, grp_low[pick_grp]};
  assign id_slot    = ght_pkg::SLOT_W'(req_q.slot_id);
  assign rd_slot    = cmd.pick ? ((req_q.func == ght_pkg::FUNC_ALLOC) ? alloc_slot : id_slot)
                               : tgt;

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      tgt        <= rd_slot;
      alloc_full <= !pick_any;
    end
  end

  ght_ram #(.WIDTH(ght_pkg::GEN_W), .DEPTH(ght_pkg::SLOTS)) u_gen_ram (
    .clk   (clk),
    .we    (rel_ok),
    .waddr (tgt),
    .wdata (gen_cur + ght_pkg::GEN_W'(1)),
    .raddr (rd_slot),
    .rdata (gen_rd)
  );

  ght_ram #(.WIDTH(ght_pkg::HANDLE_W), .DEPTH(ght_pkg::SLOTS)) u_handle_ram (
    .clk   (clk),
    .we    (alloc_ok),
    .waddr (tgt),
    .wdata (req_q.handle),
    .raddr (rd_slot),
    .rdata (handle_rd)
  );

  assign gen_cur = gen_valid[tgt] ? gen_rd : '0;
  assign id_bad  = (req_q.slot_id == '0) || (32'(req_q.slot_id) >= 32'(hw));

  always_comb begin
    if (id_bad)                             chk_st = ght_pkg::ST_BAD_ID;
    else if (gen_cur != req_q.generation)   chk_st = ght_pkg::ST_STALE;
    else if (!occupied[tgt])                chk_st = ght_pkg::ST_EMPTY;
    else                                    chk_st = ght_pkg::ST_OK;
  end

  always_comb begin
    rsp_c                = '0;
    rsp_c.out_slot       = req_q.slot_id;
    case (req_q.func)
      ght_pkg::FUNC_ALLOC: begin
        if (alloc_full) begin
          rsp_c.status   = ght_pkg::ST_FULL;
          rsp_c.out_slot = '0;
        end else begin
          rsp_c.status         = ght_pkg::ST_OK;
          rsp_c.out_slot       = ght_pkg::ID_W'(tgt);
          rsp_c.out_generation = gen_cur;
        end
      end
      ght_pkg::FUNC_RELEASE: begin
        rsp_c.status = chk_st;
      end
      ght_pkg::FUNC_LOOKUP: begin
        rsp_c.status = chk_st;
        if (chk_st == ght_pkg::ST_OK) rsp_c.out_handle = handle_rd;
      end
      default: begin
        rsp_c.status = ght_pkg::ST_BAD_ID;
      end
    endcase
  end

  assign alloc_ok = cmd.commit && (req_q.func == ght_pkg::FUNC_ALLOC) && !alloc_full;
  assign rel_ok   = cmd.commit && (req_q.func == ght_pkg::FUNC_RELEASE) &&
                    (chk_st == ght_pkg::ST_OK);

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied  <= '0;
      gen_valid <= '0;
      hw        <= ght_pkg::HW_W'(1);
    end else begin
      if (alloc_ok) begin
        occupied[tgt] <= 1'b1;
        if (ght_pkg::HW_W'(tgt) == hw) hw <= hw + ght_pkg::HW_W'(1);
      end
      if (rel_ok) begin
        occupied[tgt]  <= 1'b0;
        gen_valid[tgt] <= 1'b1;
      end
    end
  end

  assign stat.out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) rsp <= rsp_c;
  end

endmodule

// ----- tb/generational_handle_table_unit_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the generational handle table: directed and random requests.
module generational_handle_table_unit_test;

  // func code 3 has no meaning; the block answers bad id
  localparam logic [ght_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 4000;  // cycles with no word moving on either side
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off for the pressure test
  localparam int DRAIN_CYCLES = 20;   // drain margin after the last response, give it plenty
  localparam int MAX_REPORTS = 10;

  logic          clk;
  logic          rst;
  logic          req_valid;
  logic          req_ready;
  ght_pkg::req_t req;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  ght_pkg::rsp_t rsp;

  generational_handle_table_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // Shadow copy of the slot table, updated as each request word is accepted.
  logic                         tbl_occ [ght_pkg::SLOTS];
  logic [ght_pkg::GEN_W-1:0]    tbl_gen [ght_pkg::SLOTS];
  logic [ght_pkg::HANDLE_W-1:0] tbl_hnd [ght_pkg::SLOTS];
  int                           tbl_mark;

  ght_pkg::rsp_t pending_rsp[$];   // responses owed by the block, oldest first
  int   mismatch_cnt = 0;
  int   send_idle_pct;    // chance per cycle that the sender sits idle
  int   recv_stall_pct;   // chance per cycle that the receiver drops ready
  int   pressure_req = 0;  // bumped by the sender side to ask for one long hold-off
  int   pressure_done = 0; // last request the receiver has served
  int   hold_left = 0;
  int   quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Id range, then generation, then occupancy -- same order the block checks.
  function automatic logic [ght_pkg::STATUS_W-1:0] slot_check(
      input int id, input logic [ght_pkg::GEN_W-1:0] g);
    if (id == 0 || id >= tbl_mark) return ght_pkg::ST_BAD_ID;
    if (tbl_gen[id] != g) return ght_pkg::ST_STALE;
    if (!tbl_occ[id]) return ght_pkg::ST_EMPTY;
    return ght_pkg::ST_OK;
  endfunction

  // Expected response for one accepted request; advances the shadow table.
  function automatic ght_pkg::rsp_t table_step(input ght_pkg::req_t w);
    ght_pkg::rsp_t r;
    int   id;
    int   pick;
    int   i;
    r = '0;
    id = int'(w.slot_id);
    pick = 0;
    case (w.func)
      ght_pkg::FUNC_ALLOC: begin
        // lowest free slot below the mark, else grow the mark, else full
        for (i = 1; i < tbl_mark && pick == 0; i++)
          if (!tbl_occ[i]) pick = i;
        if (pick == 0 && tbl_mark < ght_pkg::SLOTS) begin
          pick = tbl_mark;
          tbl_mark++;
        end
        if (pick == 0) begin
          r.status = ght_pkg::ST_FULL;
        end else begin
          tbl_occ[pick] = 1'b1;
          tbl_hnd[pick] = w.handle;
          r.status = ght_pkg::ST_OK;
          r.out_slot = ght_pkg::ID_W'(pick);
          r.out_generation = tbl_gen[pick];
        end
      end
      ght_pkg::FUNC_RELEASE: begin
        r.status = slot_check(id, w.generation);
        r.out_slot = w.slot_id;
        if (r.status == ght_pkg::ST_OK) begin
          tbl_occ[id] = 1'b0;
          tbl_gen[id] = tbl_gen[id] + ght_pkg::GEN_W'(1);
        end
      end
      ght_pkg::FUNC_LOOKUP: begin
        r.status = slot_check(id, w.generation);
        r.out_slot = w.slot_id;
        if (r.status == ght_pkg::ST_OK) r.out_handle = tbl_hnd[id];
      end
      default: begin
        r.status = ght_pkg::ST_BAD_ID;
        r.out_slot = w.slot_id;
      end
    endcase
    return r;
  endfunction

  function automatic ght_pkg::req_t make_word(input logic [ght_pkg::FUNC_W-1:0] f,
                                              input logic [ght_pkg::HANDLE_W-1:0] h,
                                              input int id,
                                              input logic [ght_pkg::GEN_W-1:0] g);
    ght_pkg::req_t w;
    w.func = f;
    w.handle = h;
    w.slot_id = ght_pkg::ID_W'(id);
    w.generation = g;
    return w;
  endfunction

  // Mostly random handles, with zero and all ones mixed in.
  function automatic logic [ght_pkg::HANDLE_W-1:0] rand_handle();
    int r;
    r = $urandom_range(15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // Random request: mostly well-formed traffic on live slots, some noise.
  function automatic ght_pkg::req_t random_word(input int alloc_pct);
    int   live[$];
    int   free_ids[$];
    int   r;
    int   s;
    int   i;
    ght_pkg::req_t w;
    w = make_word(ght_pkg::FUNC_LOOKUP, $urandom, $urandom_range(63), $urandom);
    for (i = 1; i < tbl_mark; i++) begin
      if (tbl_occ[i]) live = {live, i};
      else free_ids = {free_ids, i};
    end
    r = $urandom_range(99);
    if (r < alloc_pct || (live.size() == 0 && r < 85)) begin
      w.func = ght_pkg::FUNC_ALLOC;
      w.handle = rand_handle();
    end else if (r < 85) begin
      s = live[$urandom_range(live.size() - 1)];
      w.func = $urandom_range(1) ? ght_pkg::FUNC_RELEASE : ght_pkg::FUNC_LOOKUP;
      w.slot_id = ght_pkg::ID_W'(s);
      w.generation = tbl_gen[s];
    end else begin
      w.func = $urandom_range(1) ? ght_pkg::FUNC_RELEASE : ght_pkg::FUNC_LOOKUP;
      case ($urandom_range(5))
        0: w.func = FUNC_UNUSED;
        1: ;  // fully random fields
        2: begin  // stale: one generation bit flipped
          if (tbl_mark > 1) begin
            s = $urandom_range(tbl_mark - 1, 1);
            w.slot_id = ght_pkg::ID_W'(s);
            w.generation = tbl_gen[s] ^ (32'h1 << $urandom_range(31));
          end
        end
        3: begin  // empty slot with its current generation
          if (free_ids.size() > 0) begin
            s = free_ids[$urandom_range(free_ids.size() - 1)];
            w.slot_id = ght_pkg::ID_W'(s);
            w.generation = tbl_gen[s];
          end
        end
        4: w.slot_id = '0;
        default: begin  // at or above the mark
          if (tbl_mark < ght_pkg::SLOTS)
            w.slot_id = ght_pkg::ID_W'($urandom_range(ght_pkg::SLOTS - 1, tbl_mark));
          else w.slot_id = '0;
        end
      endcase
    end
    return w;
  endfunction

  // Offer one word, hold it until accepted, then record what it should return.
  task automatic send_word(input ght_pkg::req_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    do @(posedge clk); while (!req_ready);
    pending_rsp = {pending_rsp, table_step(w)};
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Extremes of every field, every operation, every status but table full.
  task automatic test_directed();
    send_word(make_word(ght_pkg::FUNC_ALLOC, 32'h0000_0001, 0, '0));    // slot 1
    send_word(make_word(ght_pkg::FUNC_ALLOC, 32'hFFFF_FFFF, 63, '1));   // slot 2
    send_word(make_word(ght_pkg::FUNC_ALLOC, 32'h0000_0000, 0, '0));    // slot 3, zero handle
    send_word(make_word(ght_pkg::FUNC_LOOKUP, '0, 1, 32'd0));
    send_word(make_word(ght_pkg::FUNC_LOOKUP, '1, 2, 32'd0));
    send_word(make_word(ght_pkg::FUNC_LOOKUP, '0, 3, 32'd0));           // zero handle comes back
    send_word(make_word(ght_pkg::FUNC_LOOKUP, '0, 1, 32'hFFFF_FFFF));   // stale
    send_word(make_word(ght_pkg::FUNC_RELEASE, '0, 0, 32'd0));          // reserved slot
    send_word(make_word(ght_pkg::FUNC_LOOKUP, '0, 0, 32'd0));
    send_word(make_word(ght_pkg::FUNC_LOOKUP, '0, 63, 32'd0));          // far past the mark
    send_word(make_word(ght_pkg::FUNC_LOOKUP, '0, 4, 32'd0));           // exactly at the mark
    send_word(make_word(FUNC_UNUSED, '1, 2, 32'd0));                    // unknown op
    send_word(make_word(FUNC_UNUSED, '0, 63, '1));
    send_word(make_word(ght_pkg::FUNC_RELEASE, '0, 2, 32'd0));          // ok, gen -> 1
    send_word(make_word(ght_pkg::FUNC_LOOKUP, '0, 2, 32'd1));           // empty
    send_word(make_word(ght_pkg::FUNC_LOOKUP, '0, 2, 32'd0));           // stale after release
    send_word(make_word(ght_pkg::FUNC_RELEASE, '0, 2, 32'd1));          // empty
    send_word(make_word(ght_pkg::FUNC_ALLOC, 32'hA5A5_5A5A, 0, '0));    // reuses slot 2, gen 1
    send_word(make_word(ght_pkg::FUNC_LOOKUP, '0, 2, 32'd1));
    send_word(make_word(ght_pkg::FUNC_RELEASE, '0, 1, 32'd0));
    send_word(make_word(ght_pkg::FUNC_RELEASE, '0, 3, 32'hFFFF_FFFE));  // stale, high bits
  endtask

  // Fill every slot, hit table full, then free a few and refill lowest first.
  task automatic test_table_full();
    int i;
    int freed[4];
    freed = '{5, 17, 40, 63};
    for (i = 0; i < ght_pkg::SLOTS + 2; i++)
      send_word(make_word(ght_pkg::FUNC_ALLOC, rand_handle(), $urandom_range(63), $urandom));
    send_word(make_word(ght_pkg::FUNC_LOOKUP, '0, 63, tbl_gen[63]));
    foreach (freed[k])
      send_word(make_word(ght_pkg::FUNC_RELEASE, '0, freed[k], tbl_gen[freed[k]]));
    send_word(make_word(ght_pkg::FUNC_LOOKUP, '0, 40, tbl_gen[40]));
    for (i = 0; i < 5; i++)
      send_word(make_word(ght_pkg::FUNC_ALLOC, rand_handle(), 0, '0));
  endtask

  task automatic test_random(input int n, input int alloc_pct);
    int i;
    for (i = 0; i < n; i++) send_word(random_word(alloc_pct));
  endtask

  // Receiver holds off for a long stretch while the sender keeps going,
  // so the response register fills and req_ready drops.
  task automatic test_backpressure();
    pressure_req = pressure_req + 1;
    test_random(40, 50);
  endtask

  // Receiver: random stalls, plus one long hold-off when asked.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      rsp_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (pressure_req != pressure_done) begin
      rsp_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      pressure_done <= pressure_req;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Response checker and watchdog.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("ERROR: response with none outstanding: status %0d slot %0d gen %h handle %h",
                   rsp.status, rsp.out_slot, rsp.out_generation, rsp.out_handle);
      end else begin
        if (rsp.status !== pending_rsp[0].status ||
            rsp.out_slot !== pending_rsp[0].out_slot ||
            rsp.out_generation !== pending_rsp[0].out_generation ||
            rsp.out_handle !== pending_rsp[0].out_handle) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("ERROR: exp status %0d slot %0d gen %h handle %h, got %0d %0d %h %h",
                     pending_rsp[0].status, pending_rsp[0].out_slot,
                     pending_rsp[0].out_generation, pending_rsp[0].out_handle,
                     rsp.status, rsp.out_slot, rsp.out_generation, rsp.out_handle);
        end
        void'(pending_rsp.pop_front());
      end
    end

    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int i;
    for (i = 0; i < ght_pkg::SLOTS; i++) begin
      tbl_occ[i] = 1'b0;
      tbl_gen[i] = '0;
      tbl_hnd[i] = '0;
    end
    tbl_mark = 1;
    set_idling(0, 0);
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_table_full();

    // each idling phase: allocation-heavy traffic, then release-heavy
    set_idling(0, 0);
    test_random(220, 60);
    test_random(220, 25);
    set_idling(64, 0);
    test_random(220, 60);
    test_random(220, 25);
    set_idling(0, 64);
    test_random(220, 60);
    test_random(220, 25);
    set_idling(0, 0);
    test_backpressure();
    set_idling(6, 6);
    test_random(220, 60);
    test_random(220, 25);

    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending_rsp.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
